// File: src/led_pkg.sv
package led_pkg;

	localparam logic [7:0] KEY_UP    = 8'hE2;
	localparam logic [7:0] KEY_DOWN  = 8'hE3;
	localparam logic [7:0] KEY_LEFT  = 8'hE4;
	localparam logic [7:0] KEY_RIGHT = 8'hE5;
	localparam logic [7:0] KEY_BS    = 8'h08;
	localparam logic [7:0] KEY_DEL   = 8'h7F;
	localparam logic [7:0] KEY_LF    = 8'h0A;
	localparam logic [7:0] KEY_CR    = 8'h0D;
	localparam logic [7:0] PRINT_LO  = 8'd32;
	localparam logic [7:0] PRINT_END = 8'd127;

	localparam logic [1:0] KIND_EDIT  = 2'd0;
	localparam logic [1:0] KIND_CHAR  = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CMP_RD,
		ST_CMP,
		ST_STORE,
		ST_EMIT_RD,
		ST_EMIT,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_STATUS,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] character;
		logic [5:0] cursor_pos;
		logic [5:0] line_length;
		logic       last;
	} result_t;

endpackage

// File: src/led_stream_if.sv
interface led_stream_if #(
	parameter int W = 8
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/led_ram.sv
module led_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: src/line_editor_with_history_unit.sv
// channel | dir | payload
// key     | in  | key_code[7:0]
// res     | out | kind, character, cursor_pos, line_length, last
// Key ready stays low while a key is processed: a key with no effect returns to idle,
// left/right move the cursor, insert/backspace shift the line, up/down load an entry, an empty
// enter emits one empty result, else a compare (newest entry of equal length only), a store
// (not on a repeat) and an emit of each character; one sequencer around a line RAM and a history RAM.
// Reset clears the line length, cursor and history pointers; RAM contents and stored entry lengths stay undefined.
// Each result waits in the output register until taken; the sequencer stalls only when it must write the next one.
module line_editor_with_history_unit #(
	parameter int LINE_SIZE     = 64,
	parameter int HISTORY_DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	led_stream_if.sink   key,
	led_stream_if.source res
);
	localparam int LW = $clog2(LINE_SIZE);
	localparam int CW = LW + 1;
	localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int NW = $clog2(HISTORY_DEPTH + 1);
	localparam int HAW = $clog2(HISTORY_DEPTH * LINE_SIZE);

	led_pkg::state_t state_q, state_d;

	logic [7:0]    key_q;
	logic [CW-1:0] len_q, cur_q, idx_q, lim_q;
	logic [NW-1:0] hcount_q, browse_q;
	logic [HW-1:0] holdest_q, slot_q;
	logic          match_q, stored_q;
	logic [CW-1:0] hent_len_q [HISTORY_DEPTH];
	led_pkg::result_t res_q;
	logic          res_valid_q;

	logic          lwe;
	logic [LW-1:0] lwaddr, lraddr;
	logic [7:0]    lwdata, lrdata;
	logic          hwe;
	logic [HAW-1:0] hwaddr, hraddr;
	logic [7:0]    hwdata, hrdata;

	led_ram #(.WIDTH(8), .DEPTH(LINE_SIZE)) u_line (
		.clk, .we(lwe), .waddr(lwaddr), .wdata(lwdata), .raddr(lraddr), .rdata(lrdata)
	);
	led_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH * LINE_SIZE)) u_hist (
		.clk, .we(hwe), .waddr(hwaddr), .wdata(hwdata), .raddr(hraddr), .rdata(hrdata)
	);

	function automatic logic [HW-1:0] slot_add(logic [HW-1:0] b, logic [NW-1:0] o);
		logic [NW:0] s;
		s = (NW+1)'(b) + (NW+1)'(o);
		if (s >= (NW+1)'(HISTORY_DEPTH)) begin
			s = s - (NW+1)'(HISTORY_DEPTH);
		end
		return HW'(s);
	endfunction

	function automatic logic [HAW-1:0] haddr(logic [HW-1:0] s, logic [CW-1:0] i);
		return HAW'(s) * HAW'(LINE_SIZE) + HAW'(i[LW-1:0]);
	endfunction

	logic is_enter, is_print, is_bs;
	assign is_enter = (key_q == led_pkg::KEY_LF) || (key_q == led_pkg::KEY_CR);
	assign is_print = (key_q >= led_pkg::PRINT_LO) && (key_q < led_pkg::PRINT_END);
	assign is_bs    = (key_q == led_pkg::KEY_BS) || (key_q == led_pkg::KEY_DEL);

	logic [HW-1:0] newest_slot;
	assign newest_slot = slot_add(holdest_q, hcount_q - NW'(1));

	logic [HW-1:0] up_slot, dn_slot;
	always_comb begin
		if (browse_q == '0) begin
			up_slot = holdest_q;
		end else if (browse_q > hcount_q) begin
			up_slot = slot_add(holdest_q, hcount_q - NW'(1));
		end else begin
			up_slot = slot_add(holdest_q, browse_q - NW'(1));
		end
		dn_slot = slot_add(holdest_q, browse_q + NW'(1));
	end

	logic [CW-1:0] up_len, dn_len;
	always_comb begin
		up_len = hent_len_q[up_slot];
		dn_len = hent_len_q[dn_slot];
		if (up_len > CW'(LINE_SIZE - 1)) begin
			up_len = CW'(LINE_SIZE - 1);
		end
		if (dn_len > CW'(LINE_SIZE - 1)) begin
			dn_len = CW'(LINE_SIZE - 1);
		end
	end

	logic res_free;
	assign res_free = !res_valid_q || res.ready;
	assign key.ready = (state_q == led_pkg::ST_IDLE);
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			led_pkg::ST_IDLE: begin
				if (key.valid) begin
					state_d = led_pkg::ST_DECODE;
				end
			end
			led_pkg::ST_DECODE: begin
				if (is_enter) begin
					if (len_q == '0) begin
						state_d = led_pkg::ST_OUT;
					end else if (hcount_q != '0 && hent_len_q[newest_slot] == len_q) begin
						state_d = led_pkg::ST_CMP_RD;
					end else begin
						state_d = led_pkg::ST_STORE;
					end
				end else if (key_q == led_pkg::KEY_LEFT) begin
					state_d = (cur_q == '0) ? led_pkg::ST_IDLE : led_pkg::ST_STATUS;
				end else if (key_q == led_pkg::KEY_RIGHT) begin
					state_d = (cur_q >= len_q) ? led_pkg::ST_IDLE : led_pkg::ST_STATUS;
				end else if (key_q == led_pkg::KEY_UP || key_q == led_pkg::KEY_DOWN) begin
					state_d = (hcount_q == '0) ? led_pkg::ST_IDLE : led_pkg::ST_LOAD_RD;
				end else if (is_bs) begin
					state_d = (cur_q == '0) ? led_pkg::ST_IDLE : led_pkg::ST_SHIFT_RD;
				end else if (is_print) begin
					state_d = (len_q >= CW'(LINE_SIZE - 1)) ? led_pkg::ST_IDLE
						: led_pkg::ST_SHIFT_RD;
				end else begin
					state_d = led_pkg::ST_IDLE;
				end
			end
			led_pkg::ST_CMP_RD: state_d = led_pkg::ST_CMP;
			led_pkg::ST_CMP: begin
				if (idx_q >= len_q) begin
					state_d = (match_q && lrdata == hrdata) ? led_pkg::ST_EMIT_RD
						: led_pkg::ST_STORE;
				end else begin
					state_d = led_pkg::ST_CMP_RD;
				end
			end
			led_pkg::ST_STORE: begin
				if (idx_q > len_q) begin
					state_d = led_pkg::ST_EMIT_RD;
				end
			end
			led_pkg::ST_EMIT_RD: state_d = led_pkg::ST_EMIT;
			led_pkg::ST_EMIT: begin
				if (res_free) begin
					state_d = (idx_q >= len_q) ? led_pkg::ST_IDLE : led_pkg::ST_EMIT_RD;
				end
			end
			led_pkg::ST_SHIFT_RD: state_d = led_pkg::ST_SHIFT_WR;
			led_pkg::ST_SHIFT_WR: begin
				state_d = (idx_q == lim_q) ? led_pkg::ST_STATUS : led_pkg::ST_SHIFT_RD;
			end
			led_pkg::ST_LOAD_RD: begin
				state_d = (idx_q >= lim_q) ? led_pkg::ST_STATUS : led_pkg::ST_LOAD_WR;
			end
			led_pkg::ST_LOAD_WR: state_d = led_pkg::ST_LOAD_RD;
			led_pkg::ST_STATUS: state_d = led_pkg::ST_OUT;
			led_pkg::ST_OUT: begin
				if (res_free) begin
					state_d = led_pkg::ST_IDLE;
				end
			end
			default: state_d = led_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		lwe    = 1'b0;
		lwaddr = idx_q[LW-1:0];
		lwdata = lrdata;
		lraddr = idx_q[LW-1:0];
		hwe    = 1'b0;
		hwaddr = haddr(slot_q, idx_q);
		hwdata = lrdata;
		hraddr = haddr(slot_q, idx_q);
		case (state_q)
			led_pkg::ST_STORE: begin
				hwe    = (idx_q != '0) && !stored_q;
				hwaddr = haddr(slot_q, idx_q - CW'(1));
				lraddr = idx_q[LW-1:0];
			end
			led_pkg::ST_EMIT: begin
				lraddr = LW'(idx_q - CW'(1));
			end
			led_pkg::ST_SHIFT_RD: begin
				lraddr = is_bs ? idx_q[LW-1:0] : LW'(idx_q - CW'(1));
			end
			led_pkg::ST_SHIFT_WR: begin
				if (is_bs) begin
					lwe    = (idx_q != lim_q);
					lwaddr = LW'(idx_q - CW'(1));
				end else begin
					lwe    = 1'b1;
					lwdata = (idx_q == lim_q) ? key_q : lrdata;
				end
			end
			led_pkg::ST_LOAD_WR: begin
				lwe    = 1'b1;
				lwaddr = LW'(idx_q - CW'(1));
				lwdata = hrdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= led_pkg::ST_IDLE;
			len_q       <= '0;
			cur_q       <= '0;
			hcount_q    <= '0;
			holdest_q   <= '0;
			browse_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				led_pkg::ST_STORE: begin
					if (idx_q > len_q && !stored_q) begin
						if (hcount_q < NW'(HISTORY_DEPTH)) begin
							hcount_q <= hcount_q + NW'(1);
						end else begin
							holdest_q <= slot_add(holdest_q, NW'(1));
						end
					end
				end
				led_pkg::ST_EMIT: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						if (idx_q >= len_q) begin
							len_q    <= '0;
							cur_q    <= '0;
							browse_q <= hcount_q;
						end
					end
				end
				led_pkg::ST_DECODE: begin
					if (key_q == led_pkg::KEY_UP && hcount_q != '0) begin
						if (browse_q == '0 || browse_q > hcount_q) begin
							browse_q <= (browse_q == '0) ? '0 : hcount_q - NW'(1);
						end else begin
							browse_q <= browse_q - NW'(1);
						end
					end else if (key_q == led_pkg::KEY_DOWN && hcount_q != '0) begin
						if (browse_q + NW'(1) >= hcount_q) begin
							browse_q <= hcount_q;
						end else begin
							browse_q <= browse_q + NW'(1);
						end
					end
				end
				led_pkg::ST_LOAD_RD: begin
					if (idx_q >= lim_q) begin
						len_q <= lim_q;
						cur_q <= lim_q;
					end
				end
				led_pkg::ST_STATUS: begin
					if (key_q == led_pkg::KEY_LEFT || is_bs) begin
						cur_q <= cur_q - CW'(1);
					end else if (key_q == led_pkg::KEY_RIGHT || is_print) begin
						cur_q <= cur_q + CW'(1);
					end
					if (is_bs) begin
						len_q <= len_q - CW'(1);
					end else if (is_print) begin
						len_q <= len_q + CW'(1);
					end
				end
				led_pkg::ST_OUT: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						if (is_enter) begin
							browse_q <= hcount_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			led_pkg::ST_IDLE: begin
				key_q <= key.data;
			end
			led_pkg::ST_DECODE: begin
				idx_q    <= '0;
				match_q  <= 1'b1;
				stored_q <= 1'b0;
				slot_q   <= newest_slot;
				if (is_enter && !(hcount_q != '0 && hent_len_q[newest_slot] == len_q)) begin
					slot_q <= (hcount_q < NW'(HISTORY_DEPTH)) ? slot_add(holdest_q, hcount_q)
						: holdest_q;
				end
				if (is_bs) begin
					idx_q <= cur_q;
					lim_q <= len_q;
				end else if (is_print) begin
					idx_q <= len_q;
					lim_q <= cur_q;
				end
				if (key_q == led_pkg::KEY_UP) begin
					if (browse_q == '0) begin
						slot_q <= holdest_q;
					end else if (browse_q > hcount_q) begin
						slot_q <= slot_add(holdest_q, hcount_q - NW'(1));
					end else begin
						slot_q <= slot_add(holdest_q, browse_q - NW'(1));
					end
				end else if (key_q == led_pkg::KEY_DOWN) begin
					slot_q <= slot_add(holdest_q, browse_q + NW'(1));
				end
			end
			led_pkg::ST_CMP_RD: begin
				idx_q <= idx_q + CW'(1);
			end
			led_pkg::ST_CMP: begin
				if (lrdata != hrdata) begin
					match_q <= 1'b0;
				end
				if (idx_q >= len_q) begin
					idx_q <= '0;
					if (!match_q || lrdata != hrdata) begin
						slot_q <= (hcount_q < NW'(HISTORY_DEPTH))
							? slot_add(holdest_q, hcount_q) : holdest_q;
					end else begin
						stored_q <= 1'b1;
					end
				end
			end
			led_pkg::ST_STORE: begin
				idx_q <= idx_q + CW'(1);
				if (idx_q > len_q) begin
					idx_q <= '0;
					if (!stored_q) begin
						hent_len_q[slot_q] <= len_q;
					end
				end
			end
			led_pkg::ST_EMIT_RD: begin
				idx_q <= idx_q + CW'(1);
			end
			led_pkg::ST_EMIT: begin
				if (res_free) begin
					res_q.kind        <= led_pkg::KIND_CHAR;
					res_q.character   <= lrdata[6:0];
					res_q.cursor_pos  <= '0;
					res_q.line_length <= '0;
					res_q.last        <= (idx_q >= len_q);
				end
			end
			led_pkg::ST_SHIFT_WR: begin
				if (idx_q != lim_q) begin
					idx_q <= is_bs ? idx_q + CW'(1) : idx_q - CW'(1);
				end
			end
			led_pkg::ST_LOAD_RD: begin
				idx_q <= idx_q + CW'(1);
			end
			default: ;
		endcase
		if (state_q == led_pkg::ST_DECODE &&
			(key_q == led_pkg::KEY_UP || key_q == led_pkg::KEY_DOWN)) begin
			lim_q <= (key_q == led_pkg::KEY_UP) ? up_len
				: ((browse_q + NW'(1) < hcount_q) ? dn_len : '0);
		end
		if (state_q == led_pkg::ST_OUT && res_free) begin
			if (is_enter) begin
				res_q.kind <= led_pkg::KIND_EMPTY;
				res_q.cursor_pos <= '0;
				res_q.line_length <= '0;
			end else begin
				res_q.kind <= led_pkg::KIND_EDIT;
				res_q.cursor_pos <= cur_q[5:0];
				res_q.line_length <= len_q[5:0];
			end
			res_q.character <= '0;
			res_q.last <= 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |=> res_valid_q && $stable(res_q))
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		key.ready |-> !(state_q == led_pkg::ST_EMIT))
		else $error("key ready while emitting");
	assert property (@(posedge clk) disable iff (!arst_n)
		hcount_q <= NW'(HISTORY_DEPTH))
		else $error("history count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q)
		else $error("cursor beyond line end");
endmodule

// File: verif/line_editor_with_history_unit_checker.sv
`timescale 1ns / 1ps
module line_editor_with_history_unit_checker #(
	parameter int LINE_SIZE     = 64,
	parameter int HISTORY_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic key_valid,
	input  logic key_ready,
	input  logic [7:0] key_data,
	input  logic res_valid,
	input  logic res_ready,
	input  logic [$bits(led_pkg::result_t)-1:0] res_data,
	output int   errors,
	output int   pending
);
	logic [6:0] ed_line [LINE_SIZE];
	int         ed_len;
	int         ed_cur;
	logic [6:0] hist_chars [HISTORY_DEPTH][LINE_SIZE];
	int         hist_len [HISTORY_DEPTH];
	int         hist_count;
	int         hist_oldest;
	int         browse;
	led_pkg::result_t expected_results [$];

	function automatic int slot_of(int logical);
		return (hist_oldest + logical) % HISTORY_DEPTH;
	endfunction

	function automatic led_pkg::result_t status_result();
		led_pkg::result_t r;
		r.kind        = led_pkg::KIND_EDIT;
		r.character   = '0;
		r.cursor_pos  = ed_cur[5:0];
		r.line_length = ed_len[5:0];
		r.last        = 1'b1;
		return r;
	endfunction

	task automatic load_entry(int logical);
		int s;
		int n;
		s = slot_of(logical);
		n = hist_len[s];
		if (n > LINE_SIZE - 1)
			n = LINE_SIZE - 1;
		for (int i = 0; i < n; i++)
			ed_line[i] = hist_chars[s][i];
		ed_len = n;
		ed_cur = n;
	endtask

	task automatic store_line();
		int  s;
		bit  same;
		if (ed_len == 0)
			return;
		if (hist_count > 0) begin
			s = slot_of(hist_count - 1);
			same = (hist_len[s] == ed_len);
			for (int i = 0; same && i < ed_len; i++)
				if (hist_chars[s][i] != ed_line[i])
					same = 0;
			if (same)
				return;
		end
		if (hist_count < HISTORY_DEPTH) begin
			s = slot_of(hist_count);
			hist_count++;
		end else begin
			s = hist_oldest;
			hist_oldest = (hist_oldest + 1) % HISTORY_DEPTH;
		end
		for (int i = 0; i < ed_len; i++)
			hist_chars[s][i] = ed_line[i];
		hist_len[s] = ed_len;
	endtask

	task automatic predict_key(logic [7:0] k);
		led_pkg::result_t r;
		int      n;
		if (k == led_pkg::KEY_LF || k == led_pkg::KEY_CR) begin
			n = ed_len;
			store_line();
			ed_len = 0;
			ed_cur = 0;
			browse = hist_count;
			if (n == 0) begin
				r = '0;
				r.kind = led_pkg::KIND_EMPTY;
				r.last = 1'b1;
				expected_results.push_back(r);
			end
			for (int i = 0; i < n; i++) begin
				r = '0;
				r.kind      = led_pkg::KIND_CHAR;
				r.character = ed_line[i];
				r.last      = (i + 1 == n);
				expected_results.push_back(r);
			end
			return;
		end
		if (k == led_pkg::KEY_LEFT) begin
			if (ed_cur == 0)
				return;
			ed_cur--;
		end else if (k == led_pkg::KEY_RIGHT) begin
			if (ed_cur >= ed_len)
				return;
			ed_cur++;
		end else if (k == led_pkg::KEY_UP) begin
			if (hist_count == 0)
				return;
			if (browse > 0)
				browse--;
			if (browse >= hist_count)
				browse = hist_count - 1;
			load_entry(browse);
		end else if (k == led_pkg::KEY_DOWN) begin
			if (hist_count == 0)
				return;
			if (browse < hist_count)
				browse++;
			if (browse >= hist_count) begin
				browse = hist_count;
				ed_len = 0;
				ed_cur = 0;
			end else begin
				load_entry(browse);
			end
		end else if (k == led_pkg::KEY_BS || k == led_pkg::KEY_DEL) begin
			if (ed_cur == 0)
				return;
			for (int i = ed_cur - 1; i + 1 < ed_len; i++)
				ed_line[i] = ed_line[i + 1];
			ed_len--;
			ed_cur--;
		end else if (k >= led_pkg::PRINT_LO && k < led_pkg::PRINT_END) begin
			if (ed_len >= LINE_SIZE - 1)
				return;
			for (int i = ed_len; i > ed_cur; i--)
				ed_line[i] = ed_line[i - 1];
			ed_line[ed_cur] = k[6:0];
			ed_cur++;
			ed_len++;
		end else begin
			return;
		end
		expected_results.push_back(status_result());
	endtask

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	initial begin
		errors      = 0;
		ed_len      = 0;
		ed_cur      = 0;
		hist_count  = 0;
		hist_oldest = 0;
		browse      = 0;
	end

	assign pending = expected_results.size();

	always @(posedge clk) begin
		led_pkg::result_t got;
		led_pkg::result_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				got = led_pkg::result_t'(res_data);
				if (expected_results.size() == 0) begin
					report("unexpected transaction");
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind)
						report($sformatf("kind got %0d expected %0d",
							got.kind, want.kind));
					if (got.character !== want.character)
						report($sformatf("character got %0d expected %0d",
							got.character, want.character));
					if (got.cursor_pos !== want.cursor_pos)
						report($sformatf("cursor_pos got %0d expected %0d",
							got.cursor_pos, want.cursor_pos));
					if (got.line_length !== want.line_length)
						report($sformatf("line_length got %0d expected %0d",
							got.line_length, want.line_length));
					if (got.last !== want.last)
						report($sformatf("last got %0d expected %0d",
							got.last, want.last));
				end
			end
			if (key_valid && key_ready)
				predict_key(key_data);
		end
	end
endmodule

// File: verif/line_editor_with_history_unit_tb.sv
`timescale 1ns / 1ps
module line_editor_with_history_unit_tb;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;

	led_stream_if #(.W(8)) key_ch ();
	led_stream_if #(.W($bits(led_pkg::result_t))) res_ch ();

	line_editor_with_history_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_ch),
		.res    (res_ch)
	);

	line_editor_with_history_unit_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_ch.valid),
		.key_ready (key_ch.ready),
		.key_data  (key_ch.data),
		.res_valid (res_ch.valid),
		.res_ready (res_ch.ready),
		.res_data  (res_ch.data),
		.errors    (errors),
		.pending   (pending)
	);

	bit no_idle;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic send_key(logic [7:0] k);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			key_ch.valid <= 1'b0;
			key_ch.data  <= $urandom;
			repeat (gap) @(negedge clk);
		end
		key_ch.valid <= 1'b1;
		key_ch.data  <= k;
		@(posedge clk);
		while (!key_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_printable();
		send_key(8'($urandom_range(led_pkg::PRINT_LO, led_pkg::PRINT_END - 1)));
	endtask

	function automatic logic [7:0] random_key();
		int c;
		c = $urandom_range(0, 19);
		case (c)
			0, 1: return led_pkg::KEY_UP;
			2: return led_pkg::KEY_DOWN;
			3: return led_pkg::KEY_LEFT;
			4: return led_pkg::KEY_RIGHT;
			5: return led_pkg::KEY_BS;
			6: return led_pkg::KEY_DEL;
			7: return led_pkg::KEY_LF;
			8: return led_pkg::KEY_CR;
			9: return 8'($urandom);
			default: return 8'($urandom_range(led_pkg::PRINT_LO, led_pkg::PRINT_END - 1));
		endcase
	endfunction

	initial begin
		int gap;
		res_ch.ready = 1'b0;
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		key_ch.valid = 1'b0;
		key_ch.data  = '0;
		no_idle = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_key(led_pkg::KEY_UP);
		send_key(led_pkg::KEY_DOWN);
		send_key(led_pkg::KEY_LEFT);
		send_key(led_pkg::KEY_BS);
		send_key(led_pkg::KEY_CR);
		send_key(8'd32);
		send_key(8'd126);
		send_key(8'hFF);
		send_key(8'h00);
		send_key(led_pkg::KEY_LEFT);
		send_key(8'd65);
		send_key(led_pkg::KEY_RIGHT);
		send_key(led_pkg::KEY_RIGHT);
		send_key(led_pkg::KEY_DEL);
		send_key(led_pkg::KEY_LF);
		send_key(8'd66);
		send_key(led_pkg::KEY_CR);
		send_key(8'd66);
		send_key(led_pkg::KEY_CR);
		send_key(led_pkg::KEY_UP);
		send_key(led_pkg::KEY_UP);
		send_key(led_pkg::KEY_UP);
		send_key(led_pkg::KEY_DOWN);
		send_key(led_pkg::KEY_DOWN);
		key_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (200) @(negedge clk);

		no_idle = 1;
		repeat (64) send_printable();
		send_key(led_pkg::KEY_CR);
		no_idle = 0;

		for (int i = 0; i < 14; i++) begin
			send_key(8'(48 + i));
			send_key(led_pkg::KEY_CR);
		end
		repeat (3) send_key(led_pkg::KEY_UP);
		repeat (2) send_key(led_pkg::KEY_DOWN);
		repeat (4) send_key(random_key());
		key_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (300) @(negedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule
